@@ hw/rtl/sip_rlc_pkg.sv @@
// Shared types, constants and character tables for the SIP request line classifier.
package sip_rlc_pkg;

  localparam int NUM_METHODS = 14;
  localparam int MAX_NAME_CHARS = 9;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  localparam logic [3:0] TYPE_NONE  = 4'd0;
  localparam logic [3:0] TYPE_OTHER = 4'd15;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_PARSE_ERR   = 2'd1,
    STATUS_UNSUPPORTED = 2'd2
  } sip_rlc_status_t;

  typedef enum logic [1:0] {
    TOK_METHOD  = 2'd0,
    TOK_URI     = 2'd1,
    TOK_VERSION = 2'd2
  } sip_rlc_token_t;

  typedef struct packed {
    logic [3:0]      request_type;
    sip_rlc_status_t status;
  } sip_rlc_result_t;

  // Method names, first character in the top byte, padded with spaces to nine characters.
  localparam logic [8*MAX_NAME_CHARS-1:0] METHOD_TEXT [NUM_METHODS] = '{
    "INVITE   ", "ACK      ", "BYE      ", "CANCEL   ", "REGISTER ",
    "OPTIONS  ", "PRACK    ", "SUBSCRIBE", "NOTIFY   ", "PUBLISH  ",
    "INFO     ", "REFER    ", "MESSAGE  ", "UPDATE   "
  };

  localparam logic [3:0] METHOD_LEN [NUM_METHODS] = '{
    4'd6, 4'd3, 4'd3, 4'd6, 4'd8, 4'd7, 4'd5, 4'd9, 4'd6, 4'd7, 4'd4, 4'd5, 4'd7, 4'd6
  };

  localparam int URI_PREFIX_LEN = 4;
  localparam logic [8*URI_PREFIX_LEN-1:0] URI_PREFIX = "sip:";
  localparam int VERSION_PREFIX_LEN = 7;
  localparam logic [8*VERSION_PREFIX_LEN-1:0] VERSION_PREFIX = "SIP/2.0";

  function automatic logic [7:0] method_char(int unsigned idx, logic [3:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (int'(pos) < MAX_NAME_CHARS) begin
      ch = METHOD_TEXT[idx][8*(MAX_NAME_CHARS-1-int'(pos)) +: 8];
    end
    return ch;
  endfunction

  function automatic logic [7:0] uri_char(logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (int'(pos) < URI_PREFIX_LEN) begin
      ch = URI_PREFIX[8*(URI_PREFIX_LEN-1-int'(pos)) +: 8];
    end
    return ch;
  endfunction

  function automatic logic [7:0] version_char(logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (int'(pos) < VERSION_PREFIX_LEN) begin
      ch = VERSION_PREFIX[8*(VERSION_PREFIX_LEN-1-int'(pos)) +: 8];
    end
    return ch;
  endfunction

endpackage

@@ hw/rtl/sip_rlc_tracker.sv @@
// Per-line parse state and the classification of a line on its final byte.
module sip_rlc_tracker
  import sip_rlc_pkg::*;
#(
  parameter int MIN_LINE_BYTES = 19,
  parameter int MAX_LINE_BYTES = 1023
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            byte_fire,
  input  logic [7:0]      line_byte,
  input  logic            last_byte,
  output sip_rlc_result_t result
);

  localparam int CW = $clog2(MAX_LINE_BYTES + 1);

  logic [CW-1:0]          byte_count_r, byte_count_nxt;
  sip_rlc_token_t         token_r, token_nxt;
  logic [NUM_METHODS-1:0] cand_r, cand_nxt;
  logic [3:0]             mlen_r, mlen_nxt;
  logic [2:0]             uri_pos_r, uri_pos_nxt;
  logic                   uri_pfx_ok_r, uri_pfx_ok_nxt;
  logic [2:0]             ver_pos_r, ver_pos_nxt;
  logic                   ver_pfx_ok_r, ver_pfx_ok_nxt;
  logic [3:0]             mtype_r, mtype_nxt;
  logic                   mempty_r, mempty_nxt;
  logic                   uri_ok_r, uri_ok_nxt;

  logic [CW-1:0]          count_upd;
  logic [3:0]             found_type;

  // First surviving candidate whose length matches the method length.
  always_comb begin
    found_type = TYPE_OTHER;
    for (int i = NUM_METHODS - 1; i >= 0; i--) begin
      if (cand_r[i] && mlen_r == METHOD_LEN[i]) begin
        found_type = 4'(i + 1);
      end
    end
  end

  always_comb begin
    count_upd      = (32'(byte_count_r) < MAX_LINE_BYTES) ? byte_count_r + 1'b1 : byte_count_r;
    token_nxt      = token_r;
    cand_nxt       = cand_r;
    mlen_nxt       = mlen_r;
    uri_pos_nxt    = uri_pos_r;
    uri_pfx_ok_nxt = uri_pfx_ok_r;
    ver_pos_nxt    = ver_pos_r;
    ver_pfx_ok_nxt = ver_pfx_ok_r;
    mtype_nxt      = mtype_r;
    mempty_nxt     = mempty_r;
    uri_ok_nxt     = uri_ok_r;

    case (token_r)
      TOK_METHOD: begin
        if (line_byte == SPACE_CHAR) begin
          mempty_nxt = (mlen_r == 4'd0);
          mtype_nxt  = found_type;
          token_nxt  = TOK_URI;
        end else begin
          for (int i = 0; i < NUM_METHODS; i++) begin
            if (mlen_r >= METHOD_LEN[i] || method_char(i, mlen_r) != line_byte) begin
              cand_nxt[i] = 1'b0;
            end
          end
          if (mlen_r != 4'd15) begin
            mlen_nxt = mlen_r + 4'd1;
          end
        end
      end
      TOK_URI: begin
        if (line_byte == SPACE_CHAR) begin
          uri_ok_nxt = uri_pfx_ok_r && (int'(uri_pos_r) >= URI_PREFIX_LEN);
          token_nxt  = TOK_VERSION;
        end else if (int'(uri_pos_r) < URI_PREFIX_LEN) begin
          if (uri_char(uri_pos_r) != line_byte) begin
            uri_pfx_ok_nxt = 1'b0;
          end
          uri_pos_nxt = uri_pos_r + 3'd1;
        end
      end
      default: begin
        if (int'(ver_pos_r) < VERSION_PREFIX_LEN) begin
          if (version_char(ver_pos_r) != line_byte) begin
            ver_pfx_ok_nxt = 1'b0;
          end
          ver_pos_nxt = ver_pos_r + 3'd1;
        end
      end
    endcase

    byte_count_nxt = count_upd;

    // The verdict uses the state as it stands after this byte.
    result.request_type = TYPE_NONE;
    if (32'(count_upd) < MIN_LINE_BYTES || token_nxt == TOK_METHOD || mempty_nxt) begin
      result.status = STATUS_PARSE_ERR;
    end else if (token_nxt == TOK_URI || !uri_ok_nxt) begin
      result.status = STATUS_UNSUPPORTED;
    end else if (!ver_pfx_ok_nxt || int'(ver_pos_nxt) < VERSION_PREFIX_LEN) begin
      result.status = STATUS_UNSUPPORTED;
    end else begin
      result.status       = STATUS_OK;
      result.request_type = mtype_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (byte_fire && last_byte)) begin
      byte_count_r <= '0;
      token_r      <= TOK_METHOD;
      cand_r       <= '1;
      mlen_r       <= '0;
      uri_pos_r    <= '0;
      uri_pfx_ok_r <= 1'b1;
      ver_pos_r    <= '0;
      ver_pfx_ok_r <= 1'b1;
      mtype_r      <= TYPE_NONE;
      mempty_r     <= 1'b0;
      uri_ok_r     <= 1'b0;
    end else if (byte_fire) begin
      byte_count_r <= byte_count_nxt;
      token_r      <= token_nxt;
      cand_r       <= cand_nxt;
      mlen_r       <= mlen_nxt;
      uri_pos_r    <= uri_pos_nxt;
      uri_pfx_ok_r <= uri_pfx_ok_nxt;
      ver_pos_r    <= ver_pos_nxt;
      ver_pfx_ok_r <= ver_pfx_ok_nxt;
      mtype_r      <= mtype_nxt;
      mempty_r     <= mempty_nxt;
      uri_ok_r     <= uri_ok_nxt;
    end
  end

endmodule

@@ hw/rtl/sip_request_line_classifier_top.sv @@
// Top level of the SIP request line classifier: input register, tracker and result register.
//
//   channel | direction | tdata                                   | tlast
//   in_     | slave     | [7:0] line_byte                         | last_byte
//   out_    | master    | [3:0] request_type, [5:4] status, pad 0 | none
//
// One beat is taken per cycle but for the stall below. A byte is registered on acceptance and
// the parse state is updated as it leaves the input register; for a final byte the result
// register is loaded as it leaves. Reset (synchronous, rst_n low) clears the parse state and both
// valid flags. Only a final byte waits in the input register, while the result register
// is full and not being read; input beats stall behind it for as long as it waits.
module sip_request_line_classifier_top
  import sip_rlc_pkg::*;
#(
  parameter int MIN_LINE_BYTES = 19,
  parameter int MAX_LINE_BYTES = 1023
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] line_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [3:0] request_type, [5:4] status, [7:6] zero
);

  logic            s1_valid_r;
  logic [7:0]      s1_byte_r;
  logic            s1_last_r;
  logic            out_valid_r;
  sip_rlc_result_t out_res_r;
  sip_rlc_result_t res;
  logic            out_free;
  logic            s1_fire;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  sip_rlc_tracker #(
    .MIN_LINE_BYTES(MIN_LINE_BYTES),
    .MAX_LINE_BYTES(MAX_LINE_BYTES)
  ) u_tracker (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_fire(s1_fire),
    .line_byte(s1_byte_r),
    .last_byte(s1_last_r),
    .result   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.status, out_res_r.request_type};

`ifndef SYNTHESIS
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> out_valid_r)
    else $error("final byte did not produce a result");

  a_error_has_no_type: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status != STATUS_OK) |-> out_res_r.request_type == TYPE_NONE)
    else $error("failed line carries a request type");

  a_no_stall_mid_line: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_last_r) |-> s1_fire)
    else $error("non-final byte held in the input register");

  a_ok_has_type: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status == STATUS_OK) |-> out_res_r.request_type != TYPE_NONE)
    else $error("accepted line has no request type");
`endif

endmodule
